// ----- hw/rtl/dq_pkg.sv -----
package dq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_PUSHED  = 3'd0,
        ST_POPPED  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4,
        ST_DUMPED  = 3'd5
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  value;
    } t_cmd;

endpackage

// ----- hw/rtl/dq_ram.sv -----
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/dq_front.sv -----
module dq_front
    import dq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_op,
    input  logic [WORD_W-1:0] i_value,
    output logic              o_busy,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       enq;
    logic       deq;

    assign o_busy      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // drop unused op codes here; they cause nothing downstream
    assign enq = i_start && !o_busy && (i_op <= OP_CLEAR);
    assign deq = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (enq) begin
                r_wp <= ~r_wp;
            end
            if (deq) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, enq} - {1'b0, deq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= '{op: t_op'(i_op), value: i_value};
        end
    end

endmodule

// ----- hw/rtl/dq_back.sv -----
module dq_back
    import dq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_strobe,
    output logic [WORD_W-1:0] o_word,
    output t_status           o_status,
    output logic              o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] TOP_IDX = IW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DUMP,
        S_WAIT
    } t_state;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    t_status           r_pend_status, n_pend_status;
    logic              r_pend_last, n_pend_last;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_word, n_out_word;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    logic              we;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     raddr;
    logic [WORD_W-1:0] rdata;
    logic              dump_last;

    function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                           input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[IW-1:0];
    endfunction

    dq_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(i_cmd.value),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign dump_last = (r_idx == r_count - CW'(1));

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_count       = r_count;
        n_idx         = r_idx;
        n_pend        = 1'b0;
        n_pend_status = r_pend_status;
        n_pend_last   = r_pend_last;
        n_out_valid   = 1'b0;
        n_out_word    = r_out_word;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        we            = 1'b0;
        waddr         = r_front;
        raddr         = r_front;
        o_cmd_pop     = 1'b0;

        // read issued last cycle: its word is on the RAM output now
        if (r_pend) begin
            n_out_valid  = 1'b1;
            n_out_word   = rdata;
            n_out_status = r_pend_status;
            n_out_last   = r_pend_last;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop    = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_word   = '0;
                    n_out_last   = 1'b1;
                    unique case (i_cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (r_count == DEPTH_C) begin
                                n_out_status = ST_FULL;
                            end else begin
                                we = 1'b1;
                                if (i_cmd.op == OP_PUSH_FRONT) begin
                                    waddr   = (r_front == '0) ? TOP_IDX
                                                              : r_front - IW'(1);
                                    n_front = waddr;
                                end else begin
                                    waddr = ring(r_front, r_count[IW-1:0]);
                                end
                                n_count      = r_count + CW'(1);
                                n_out_status = ST_PUSHED;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_valid   = 1'b0;
                                n_pend        = 1'b1;
                                n_pend_status = ST_POPPED;
                                n_pend_last   = 1'b1;
                                n_count       = r_count - CW'(1);
                                if (i_cmd.op == OP_POP_FRONT) begin
                                    raddr   = r_front;
                                    n_front = ring(r_front, IW'(1));
                                end else begin
                                    raddr = ring(r_front, IW'(r_count - CW'(1)));
                                end
                                // rewind the ring when it goes empty
                                if (r_count == CW'(1)) begin
                                    n_front = '0;
                                end
                                n_state = S_WAIT;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_idx       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                        OP_CLEAR: begin
                            n_front      = '0;
                            n_count      = '0;
                            n_out_status = ST_CLEARED;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                raddr         = ring(r_front, r_idx[IW-1:0]);
                n_pend        = 1'b1;
                n_pend_status = ST_DUMPED;
                n_pend_last   = dump_last;
                n_idx         = r_idx + CW'(1);
                if (dump_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_idx         <= n_idx;
        r_pend_status <= n_pend_status;
        r_pend_last   <= n_pend_last;
        r_out_word    <= n_out_word;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end

    assign o_strobe = r_out_valid;
    assign o_word   = r_out_word;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

endmodule

// ----- hw/rtl/double_ended_queue_core.sv -----
// Double-ended queue of signed 32-bit words in a ring RAM of DEPTH entries.
// Command channel: a transaction is taken at a clock edge with i_start high
// and o_busy low; i_op selects push front, push back, pop front, pop back,
// dump or clear, and i_value carries the word to push. Op codes 6 and 7 are
// taken and ignored.
// Result channel: each result sits on o_word, o_status and o_last for one
// cycle, marked by o_strobe; o_last flags the final result of a command.
// The receiver cannot stall, so results are never held back.
// A two-entry command queue sits between the accept side and the executor,
// so o_busy rises only when two commands wait.
// A command passes through the command queue and the executor to the result
// registers; a pop also passes the registered RAM read. The executor handles
// push, clear and reports while idle, holds a pop through a wait state, and
// runs a dump as one RAM read per stored entry followed by a wait state.
// Reset (synchronous, i_rst_n low) empties the queue and the command queue;
// RAM contents are not cleared and are never read before they are written.
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic signed [31:0] o_word,
    output logic [2:0]         o_status,
    output logic               o_last
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    t_status status;

    dq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_op       (i_op),
        .i_value    (i_value),
        .o_busy     (o_busy),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    dq_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_strobe   (o_strobe),
        .o_word     (o_word),
        .o_status   (status),
        .o_last     (o_last)
    );

    assign o_status = status;

endmodule
